/* hdl/mssr_pkg.sv */
// ----------------------------------------------------------------------------
// mssr_pkg
// Shared widths, micro-op and condition codes, and the microcode control
// store of the motor soft start ramp sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mssr_pkg;

  localparam int DUTY_W         = 8;
  localparam int STEP_W         = 10;
  localparam int PROD_W         = DUTY_W + STEP_W;
  localparam int DCNT_W         = $clog2(DUTY_W);
  localparam int MAX_RAMP_STEPS = 1023;

  localparam logic [STEP_W-1:0] UP_STEPS_RST   = 10'd200;
  localparam logic [STEP_W-1:0] DOWN_STEPS_RST = 10'd100;

  // Configuration register indexes.
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_UP_STEPS   = 1'b0;
  localparam logic [CFG_AW-1:0] REG_DOWN_STEPS = 1'b1;

  // Micro-operations carried out by the datapath.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
  localparam logic [OP_W-1:0] OP_TAKE    = 4'd1;
  localparam logic [OP_W-1:0] OP_ABORT   = 4'd2;
  localparam logic [OP_W-1:0] OP_SETUP   = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL     = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV     = 4'd5;
  localparam logic [OP_W-1:0] OP_APPLY   = 4'd6;
  localparam logic [OP_W-1:0] OP_DRIVE   = 4'd7;
  localparam logic [OP_W-1:0] OP_BRAKE   = 4'd8;
  localparam logic [OP_W-1:0] OP_ADVANCE = 4'd9;
  localparam logic [OP_W-1:0] OP_FINISH  = 4'd10;
  localparam logic [OP_W-1:0] OP_EMIT    = 4'd11;

  // Jump conditions.
  localparam int CND_W = 4;
  localparam logic [CND_W-1:0] CND_ALWAYS     = 4'd0;
  localparam logic [CND_W-1:0] CND_NO_ITEM    = 4'd1;
  localparam logic [CND_W-1:0] CND_TICK       = 4'd2;
  localparam logic [CND_W-1:0] CND_BRAKE      = 4'd3;
  localparam logic [CND_W-1:0] CND_RUNNING    = 4'd4;
  localparam logic [CND_W-1:0] CND_ZERO_STEPS = 4'd5;
  localparam logic [CND_W-1:0] CND_DIV_MORE   = 4'd6;
  localparam logic [CND_W-1:0] CND_NO_RAMP    = 4'd7;
  localparam logic [CND_W-1:0] CND_IDX_LT     = 4'd8;
  localparam logic [CND_W-1:0] CND_OUT_FULL   = 4'd9;

  // Program addresses.
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] A_IDLE    = 4'd0;
  localparam logic [UPC_W-1:0] A_KIND    = 4'd1;
  localparam logic [UPC_W-1:0] A_ABORT   = 4'd2;
  localparam logic [UPC_W-1:0] A_CHOOSE  = 4'd3;
  localparam logic [UPC_W-1:0] A_SETUP   = 4'd4;
  localparam logic [UPC_W-1:0] A_MUL     = 4'd5;
  localparam logic [UPC_W-1:0] A_DIV     = 4'd6;
  localparam logic [UPC_W-1:0] A_APPLY   = 4'd7;
  localparam logic [UPC_W-1:0] A_DRIVE   = 4'd8;
  localparam logic [UPC_W-1:0] A_BRAKE   = 4'd9;
  localparam logic [UPC_W-1:0] A_TICK    = 4'd10;
  localparam logic [UPC_W-1:0] A_ADVANCE = 4'd11;
  localparam logic [UPC_W-1:0] A_FINISH  = 4'd12;
  localparam logic [UPC_W-1:0] A_EMIT    = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CND_W-1:0] cnd;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // Status flags the datapath hands to the sequencer.
  typedef struct packed {
    logic no_item;
    logic tick;
    logic brake;
    logic running;
    logic zero_steps;
    logic div_more;
    logic no_ramp;
    logic idx_lt;
    logic out_full;
  } flags_t;

  // Control store. A taken jump loads target, otherwise the step counter
  // advances; the emit step wraps to the idle step.
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    case (addr)
      A_IDLE:    w = '{OP_TAKE,    CND_NO_ITEM,    A_IDLE};
      A_KIND:    w = '{OP_NOP,     CND_TICK,       A_TICK};
      A_ABORT:   w = '{OP_ABORT,   CND_BRAKE,      A_BRAKE};
      A_CHOOSE:  w = '{OP_NOP,     CND_RUNNING,    A_DRIVE};
      A_SETUP:   w = '{OP_SETUP,   CND_ZERO_STEPS, A_EMIT};
      A_MUL:     w = '{OP_MUL,     CND_ALWAYS,     A_DIV};
      A_DIV:     w = '{OP_DIV,     CND_DIV_MORE,   A_DIV};
      A_APPLY:   w = '{OP_APPLY,   CND_ALWAYS,     A_EMIT};
      A_DRIVE:   w = '{OP_DRIVE,   CND_ALWAYS,     A_EMIT};
      A_BRAKE:   w = '{OP_BRAKE,   CND_ALWAYS,     A_EMIT};
      A_TICK:    w = '{OP_NOP,     CND_NO_RAMP,    A_EMIT};
      A_ADVANCE: w = '{OP_ADVANCE, CND_IDX_LT,     A_MUL};
      A_FINISH:  w = '{OP_FINISH,  CND_ALWAYS,     A_EMIT};
      A_EMIT:    w = '{OP_EMIT,    CND_OUT_FULL,   A_EMIT};
      default:   w = '{OP_NOP,     CND_ALWAYS,     A_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hdl/mssr_seq.sv */
// ----------------------------------------------------------------------------
// mssr_seq
// Microcode sequencer: step counter, control store and jump condition select.
// ----------------------------------------------------------------------------
`default_nettype none

module mssr_seq (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire mssr_pkg::flags_t       flags,
  output logic [mssr_pkg::OP_W-1:0]   op
);

  logic [mssr_pkg::UPC_W-1:0] upc;
  logic [mssr_pkg::UPC_W-1:0] upc_next;
  mssr_pkg::ucode_t           word;
  logic                       taken;

  assign word = mssr_pkg::ucode_rom(upc);
  assign op   = word.op;

  always_comb begin
    case (word.cnd)
      mssr_pkg::CND_ALWAYS:     taken = 1'b1;
      mssr_pkg::CND_NO_ITEM:    taken = flags.no_item;
      mssr_pkg::CND_TICK:       taken = flags.tick;
      mssr_pkg::CND_BRAKE:      taken = flags.brake;
      mssr_pkg::CND_RUNNING:    taken = flags.running;
      mssr_pkg::CND_ZERO_STEPS: taken = flags.zero_steps;
      mssr_pkg::CND_DIV_MORE:   taken = flags.div_more;
      mssr_pkg::CND_NO_RAMP:    taken = flags.no_ramp;
      mssr_pkg::CND_IDX_LT:     taken = flags.idx_lt;
      mssr_pkg::CND_OUT_FULL:   taken = flags.out_full;
      default:                  taken = 1'b0;
    endcase
    upc_next = taken ? word.target : upc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= mssr_pkg::A_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/motor_soft_start_ramp.sv */
// ----------------------------------------------------------------------------
// motor_soft_start_ramp
// Motor duty sequencer with linear soft start and soft stop, run by a short
// microprogram over a small datapath with a bit-serial divider.
// ----------------------------------------------------------------------------
// Usage. Each word on the input stream is either a ramp tick (s_tuser low) or
// a new command (s_tuser high) carrying a brake request and a signed duty.
// Every input word produces exactly one output word with the duty now driven
// to the bridge, the brake flag and a flag that is set while a ramp runs.
// The step counts of the up and down ramps are written through the plain
// configuration port (cfg_we, cfg_addr, cfg_data) while the block is idle.
//
// Timing. A word is taken only while the sequencer sits in its idle step.
// A tick outside a ramp finishes soonest, then a brake, then a jump, a zero
// step count or the tick that ends a ramp, then a ramp step on a tick; the
// first step that a command starts takes longest. A ramp step costs most
// because of the serial divider (one quotient bit per cycle). The next word
// is accepted the cycle after the result is loaded, so the block works on
// one word at a time.
//
// Reset (rst, synchronous) stops the ramp, clears speed and brake state and
// restores the step counts to 200 up and 100 down. When the receiver stalls,
// the result waits in the output register and the sequencer holds in its
// emit step; a new word is not taken until that result is moved out.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_soft_start_ramp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration write port.
  input  wire logic                          cfg_we,
  input  wire logic [mssr_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [mssr_pkg::STEP_W-1:0]   cfg_data,
  // Input stream.
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [15:0]                   s_tdata,  // brake_req[0], duty_req[8:1], zero
  input  wire logic                          s_tuser,  // func: 0 tick, 1 command
  // Output stream.
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [15:0]                        m_tdata   // speed_out[7:0], brake_out[8],
                                                       // ramping[9], zero
);

  localparam int DW = mssr_pkg::DUTY_W;
  localparam int SW = mssr_pkg::STEP_W;

  // Configuration registers.
  logic [SW-1:0] up_steps;
  logic [SW-1:0] down_steps;

  // Latched input word.
  logic          func_r;
  logic          brake_r;
  logic [DW-1:0] duty_r;

  // Ramp state.
  logic [DW-1:0] speed_now;
  logic [DW-1:0] ramp_start;
  logic [DW-1:0] ramp_target;
  logic [SW-1:0] step_index;
  logic [SW-1:0] step_total;
  logic          ramp_active;
  logic          ramp_is_up;
  logic [DW-1:0] logical_duty;
  logic          braked;

  // Multiply and serial divide.
  logic [SW-1:0]                 div_rem;
  logic [DW-1:0]                 div_sr;
  logic [mssr_pkg::DCNT_W-1:0]   div_cnt;
  logic                          div_neg;

  // Output register.
  logic [DW-1:0] out_speed;
  logic          out_brake;
  logic          out_ramping;

  logic [mssr_pkg::OP_W-1:0] op;
  mssr_pkg::flags_t          flags;

  // Step count for the ramp a command would start, clamped to the limit.
  logic [SW-1:0] steps_raw;
  logic [SW-1:0] steps_sel;
  logic [DW-1:0] cmd_target;
  logic          duty_zero;

  logic [DW:0]                   diff;
  logic [DW:0]                   diff_abs;
  logic [mssr_pkg::PROD_W-1:0]   prod_mag;
  logic [SW:0]                   rem_sh;
  logic                          rem_ge;
  logic [SW:0]                   rem_sub;
  logic [DW:0]                   quo_signed;
  logic [DW:0]                   apply_sum;
  logic                          out_full;

  assign duty_zero  = (duty_r == '0);
  assign steps_raw  = duty_zero ? down_steps : up_steps;
  assign steps_sel  = (32'(steps_raw) > 32'(mssr_pkg::MAX_RAMP_STEPS))
                    ? SW'(mssr_pkg::MAX_RAMP_STEPS) : steps_raw;
  assign cmd_target = duty_zero ? '0 : duty_r;

  // Distance of the ramp times the step number, as sign and magnitude.
  assign diff     = {ramp_target[DW-1], ramp_target} - {ramp_start[DW-1], ramp_start};
  assign diff_abs = diff[DW] ? -diff : diff;
  assign prod_mag = {{SW{1'b0}}, diff_abs[DW-1:0]} * {{DW{1'b0}}, step_index};

  // One restoring division step; the remainder always stays below the divisor.
  assign rem_sh  = {div_rem, div_sr[DW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, step_total});
  assign rem_sub = rem_sh - {1'b0, step_total};

  // The quotient is truncated toward zero, so the sign goes on afterwards.
  assign quo_signed = div_neg ? -{1'b0, div_sr} : {1'b0, div_sr};
  assign apply_sum  = {ramp_start[DW-1], ramp_start} + quo_signed;

  assign out_full = m_tvalid && !m_tready;

  always_comb begin
    flags.no_item    = !s_tvalid;
    flags.tick       = !func_r;
    flags.brake      = brake_r;
    flags.running    = !duty_zero && (logical_duty != '0);
    flags.zero_steps = (steps_sel == '0);
    flags.div_more   = (div_cnt != '0);
    flags.no_ramp    = !ramp_active;
    flags.idx_lt     = (step_index < step_total);
    flags.out_full   = out_full;
  end

  mssr_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .op    (op)
  );

  assign s_tready = (op == mssr_pkg::OP_TAKE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      up_steps   <= mssr_pkg::UP_STEPS_RST;
      down_steps <= mssr_pkg::DOWN_STEPS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        mssr_pkg::REG_UP_STEPS:   up_steps   <= cfg_data;
        mssr_pkg::REG_DOWN_STEPS: down_steps <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input latch, arithmetic and output data registers carry no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func_r  <= s_tuser;
      brake_r <= s_tdata[0];
      duty_r  <= s_tdata[DW:1];
    end
    case (op)
      mssr_pkg::OP_MUL: begin
        div_rem <= prod_mag[mssr_pkg::PROD_W-1:DW];
        div_sr  <= prod_mag[DW-1:0];
        div_cnt <= mssr_pkg::DCNT_W'(DW - 1);
        div_neg <= diff[DW];
      end
      mssr_pkg::OP_DIV: begin
        div_rem <= rem_ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
        div_sr  <= {div_sr[DW-2:0], rem_ge};
        div_cnt <= div_cnt - 1'b1;
      end
      default: ;
    endcase
    if (op == mssr_pkg::OP_EMIT && !out_full) begin
      out_speed   <= speed_now;
      out_brake   <= braked;
      out_ramping <= ramp_active;
    end
  end

  // Ramp state, updated by the micro-operations.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_now    <= '0;
      ramp_start   <= '0;
      ramp_target  <= '0;
      step_index   <= '0;
      step_total   <= '0;
      ramp_active  <= 1'b0;
      ramp_is_up   <= 1'b0;
      logical_duty <= '0;
      braked       <= 1'b0;
    end else begin
      case (op)
        mssr_pkg::OP_ABORT: begin
          // An aborted ramp up keeps the speed reached as the logical duty.
          if (ramp_active) begin
            ramp_active  <= 1'b0;
            logical_duty <= ramp_is_up ? speed_now : '0;
          end
        end
        mssr_pkg::OP_SETUP: begin
          if (steps_sel == '0) begin
            speed_now    <= cmd_target;
            braked       <= 1'b0;
            logical_duty <= cmd_target;
          end else begin
            ramp_start   <= speed_now;
            ramp_target  <= cmd_target;
            step_total   <= steps_sel;
            step_index   <= SW'(1);
            ramp_active  <= 1'b1;
            ramp_is_up   <= !duty_zero;
            logical_duty <= '0;
          end
        end
        mssr_pkg::OP_APPLY: begin
          speed_now <= apply_sum[DW-1:0];
          braked    <= 1'b0;
        end
        mssr_pkg::OP_DRIVE: begin
          speed_now    <= duty_r;
          braked       <= 1'b0;
          logical_duty <= duty_r;
        end
        mssr_pkg::OP_BRAKE: begin
          speed_now    <= '0;
          braked       <= 1'b1;
          logical_duty <= '0;
        end
        mssr_pkg::OP_ADVANCE: begin
          if (step_index < step_total) begin
            step_index <= step_index + 1'b1;
          end
        end
        mssr_pkg::OP_FINISH: begin
          speed_now    <= ramp_target;
          braked       <= 1'b0;
          ramp_active  <= 1'b0;
          logical_duty <= ramp_is_up ? ramp_target : '0;
        end
        default: ;
      endcase
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (op == mssr_pkg::OP_EMIT && !out_full) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {6'b0, out_ramping, out_brake, out_speed};

  // A held brake always comes with zero speed.
  a_brake_zero: assert property (@(posedge clk) disable iff (rst)
    braked |-> (speed_now == '0))
    else $error("brake held with nonzero speed");

  // A running ramp has a step number within its step count.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    ramp_active |-> (step_total != '0) && (step_index != '0) &&
                    (step_index <= step_total))
    else $error("ramp step outside its range");

  // Only one word is in work at a time.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted during work");

  // A stalled result is not overwritten.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

`default_nettype wire
